// ===== sv/ossc_pkg.sv =====
// ----------------------------------------------------------------------------
// Odd-only prime sieve counter package
// Shared widths, defaults and the microcode ROM of the sieve sequencer.
// ----------------------------------------------------------------------------
package ossc_pkg;

  // Fixed field widths of the request and result transactions.
  localparam int LIMIT_W = 17;
  localparam int COUNT_W = 15;

  // Largest limit the request field can carry.
  localparam int LIMIT_FIELD_MAX = (1 << LIMIT_W) - 1;

  localparam int MAX_LIMIT_DEF = 65536;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Sieving prime and its square. The limit field is 17 bits wide, so a
  // sieving prime stays below 2^9 and its square below 2^18.
  localparam int P_W  = 10;
  localparam int SQ_W = 19;

  localparam int PC_W = 4;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_FILL,
    OP_PINIT,
    OP_PREAD,
    OP_OFFSET,
    OP_CROSS,
    OP_PNEXT,
    OP_CINIT,
    OP_COUNT,
    OP_FIN
  } op_t;

  typedef enum logic [2:0] {
    J_NONE,
    J_ALWAYS,
    J_ERR,
    J_SQ_GT,
    J_NOT_CAND,
    J_OFF_LT,
    J_MORE,
    J_OUT_BUSY
  } jcond_t;

  typedef struct packed {
    op_t              op;
    jcond_t           cond;
    logic [PC_W-1:0]  target;
  } uword_t;

  // Step numbers of the program.
  localparam logic [PC_W-1:0] ST_CHK   = 4'd0;
  localparam logic [PC_W-1:0] ST_FILL  = 4'd1;
  localparam logic [PC_W-1:0] ST_PINIT = 4'd2;
  localparam logic [PC_W-1:0] ST_PTEST = 4'd3;
  localparam logic [PC_W-1:0] ST_PCHK  = 4'd4;
  localparam logic [PC_W-1:0] ST_CROSS = 4'd5;
  localparam logic [PC_W-1:0] ST_PNEXT = 4'd6;
  localparam logic [PC_W-1:0] ST_CINIT = 4'd7;
  localparam logic [PC_W-1:0] ST_CNT   = 4'd8;
  localparam logic [PC_W-1:0] ST_DRAIN = 4'd9;
  localparam logic [PC_W-1:0] ST_FIN   = 4'd10;

  // A taken jump loads the target; otherwise the step counter advances,
  // except that the finish step returns to the first step.
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{op: OP_NOP, cond: J_NONE, target: ST_CHK};
    unique case (pc)
      ST_CHK:   w = '{op: OP_NOP,    cond: J_ERR,      target: ST_FIN};
      ST_FILL:  w = '{op: OP_FILL,   cond: J_MORE,     target: ST_FILL};
      ST_PINIT: w = '{op: OP_PINIT,  cond: J_NONE,     target: ST_CHK};
      ST_PTEST: w = '{op: OP_PREAD,  cond: J_SQ_GT,    target: ST_CINIT};
      ST_PCHK:  w = '{op: OP_OFFSET, cond: J_NOT_CAND, target: ST_PNEXT};
      ST_CROSS: w = '{op: OP_CROSS,  cond: J_OFF_LT,   target: ST_CROSS};
      ST_PNEXT: w = '{op: OP_PNEXT,  cond: J_ALWAYS,   target: ST_PTEST};
      ST_CINIT: w = '{op: OP_CINIT,  cond: J_NONE,     target: ST_CHK};
      ST_CNT:   w = '{op: OP_COUNT,  cond: J_MORE,     target: ST_CNT};
      ST_DRAIN: w = '{op: OP_NOP,    cond: J_NONE,     target: ST_CHK};
      ST_FIN:   w = '{op: OP_FIN,    cond: J_OUT_BUSY, target: ST_FIN};
      default:  w = '{op: OP_FIN,    cond: J_OUT_BUSY, target: ST_FIN};
    endcase
    return w;
  endfunction

endpackage

// ===== sv/ossc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ossc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 32767,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/odd_only_prime_sieve_counter.sv =====
// ----------------------------------------------------------------------------
// Odd-only prime sieve counter
// Counts the odd primes from 3 up to a requested limit with a sieve of
// Eratosthenes over one mark bit per odd number.
// ----------------------------------------------------------------------------
// Each request carries a limit n and returns one result: the number of odd
// primes in 3..n (the prime 2 is not counted) and an error flag. A limit
// above MAX_LIMIT returns a count of zero with the error flag set and
// leaves the mark store alone. Otherwise, the request works on
// E = floor((n-1)/2) marks, and its run time is set by the mark store,
// which is written or read once per cycle, first to set all marks, then
// to cross off multiples, then in the counting pass. One request is worked
// on at a time; the next one is taken as soon as the result has moved to
// the output register, even while that result still waits to be taken.
// The mark store needs no clearing after reset since every request sets
// its marks first.
// ----------------------------------------------------------------------------
module odd_only_prime_sieve_counter #(
  parameter int MAX_LIMIT = ossc_pkg::MAX_LIMIT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [ossc_pkg::LIMIT_W-1:0] in_limit,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ossc_pkg::COUNT_W-1:0] out_odd_prime_count,
  output logic                         out_limit_error
);

  localparam int MAX_N       = (MAX_LIMIT < ossc_pkg::LIMIT_FIELD_MAX) ?
                               MAX_LIMIT : ossc_pkg::LIMIT_FIELD_MAX;
  localparam int MARK_DEPTH  = (MAX_N - 1) / 2;
  localparam int AW          = $clog2(MARK_DEPTH);
  localparam int ENT_W       = $clog2(MARK_DEPTH + 1);
  localparam int OFF_W       = ENT_W + 1;
  localparam int P_W         = ossc_pkg::P_W;
  localparam int SQ_W        = ossc_pkg::SQ_W;
  localparam int PC_W        = ossc_pkg::PC_W;
  localparam int LIMIT_W     = ossc_pkg::LIMIT_W;
  localparam int COUNT_W     = ossc_pkg::COUNT_W;

  // Control registers.
  logic                busy_r, busy_nxt;
  logic [PC_W-1:0]     pc_r, pc_nxt;
  logic                pend_r, pend_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Datapath registers.
  logic [LIMIT_W-1:0]  n_r, n_nxt;
  logic [ENT_W-1:0]    entries_r, entries_nxt;
  logic                err_r, err_nxt;
  logic [ENT_W-1:0]    idx_r, idx_nxt;
  logic [P_W-1:0]      p_r, p_nxt;
  logic [SQ_W-1:0]     sq_r, sq_nxt;
  logic [OFF_W-1:0]    off_r, off_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic [COUNT_W-1:0]  out_count_r, out_count_nxt;
  logic                out_err_r, out_err_nxt;

  ossc_pkg::uword_t    uw;
  logic                in_acc;
  logic                take;
  logic                out_free;
  logic [P_W-1:0]      pi;
  logic                pi_in;
  logic                idx_in;
  logic                more;
  logic                off_lt;
  logic [LIMIT_W-1:0]  limit_m1;

  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic                mem_wdata;
  logic [AW-1:0]       mem_raddr;
  logic                mem_rdata;

  assign uw       = ossc_pkg::ucode(pc_r);
  assign in_stall = busy_r;
  assign in_acc   = in_valid && !busy_r;
  assign out_free = !out_valid_r || !out_stall;

  // Index of the current sieving prime p = 2*i + 3.
  assign pi       = (p_r - P_W'(3)) >> 1;
  assign pi_in    = 32'(pi) < 32'(entries_r);
  assign idx_in   = 32'(idx_r) < 32'(entries_r);
  assign more     = (32'(idx_r) + 32'd1) < 32'(entries_r);
  assign off_lt   = 32'(off_r) < 32'(entries_r);
  assign limit_m1 = in_limit - LIMIT_W'(1);

  always_comb begin
    unique case (uw.cond)
      ossc_pkg::J_NONE:     take = 1'b0;
      ossc_pkg::J_ALWAYS:   take = 1'b1;
      ossc_pkg::J_ERR:      take = err_r;
      ossc_pkg::J_SQ_GT:    take = 32'(sq_r) > 32'(n_r);
      ossc_pkg::J_NOT_CAND: take = !(pi_in && mem_rdata);
      ossc_pkg::J_OFF_LT:   take = off_lt;
      ossc_pkg::J_MORE:     take = more;
      ossc_pkg::J_OUT_BUSY: take = !out_free;
    endcase
  end

  always_comb begin
    busy_nxt      = busy_r;
    pc_nxt        = pc_r;
    pend_nxt      = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    n_nxt         = n_r;
    entries_nxt   = entries_r;
    err_nxt       = err_r;
    idx_nxt       = idx_r;
    p_nxt         = p_r;
    sq_nxt        = sq_r;
    off_nxt       = off_r;
    count_nxt     = count_r;
    out_count_nxt = out_count_r;
    out_err_nxt   = out_err_r;
    mem_we        = 1'b0;
    mem_waddr     = idx_r[AW-1:0];
    mem_wdata     = 1'b1;
    mem_raddr     = idx_r[AW-1:0];

    // Marks read in the counting pass arrive in the cycle after the read.
    if (pend_r && mem_rdata && count_r != ossc_pkg::COUNT_MAX) begin
      count_nxt = count_r + COUNT_W'(1);
    end

    if (!busy_r) begin
      pc_nxt = ossc_pkg::ST_CHK;
      if (in_acc) begin
        busy_nxt    = 1'b1;
        n_nxt       = in_limit;
        err_nxt     = 32'(in_limit) > 32'(MAX_LIMIT);
        entries_nxt = (in_limit == '0) ? '0 : ENT_W'(limit_m1 >> 1);
        idx_nxt     = '0;
        count_nxt   = '0;
      end
    end else begin
      if (take) begin
        pc_nxt = uw.target;
      end else if (uw.op == ossc_pkg::OP_FIN) begin
        pc_nxt = ossc_pkg::ST_CHK;
      end else begin
        pc_nxt = pc_r + PC_W'(1);
      end

      unique case (uw.op)
        ossc_pkg::OP_NOP: begin
        end
        ossc_pkg::OP_FILL: begin
          mem_we  = idx_in;
          idx_nxt = idx_r + ENT_W'(1);
        end
        ossc_pkg::OP_PINIT: begin
          p_nxt  = P_W'(3);
          sq_nxt = SQ_W'(9);
        end
        ossc_pkg::OP_PREAD: begin
          mem_raddr = AW'(pi);
        end
        ossc_pkg::OP_OFFSET: begin
          // p*p is odd, so (p*p - 3) / 2 is (p*p >> 1) - 1.
          off_nxt = OFF_W'(sq_r >> 1) - OFF_W'(1);
        end
        ossc_pkg::OP_CROSS: begin
          mem_waddr = off_r[AW-1:0];
          mem_wdata = 1'b0;
          if (off_lt) begin
            mem_we  = 1'b1;
            off_nxt = off_r + OFF_W'(p_r);
          end
        end
        ossc_pkg::OP_PNEXT: begin
          // (p + 2)^2 = p^2 + 4p + 4
          p_nxt  = p_r + P_W'(2);
          sq_nxt = sq_r + (SQ_W'(p_r) << 2) + SQ_W'(4);
        end
        ossc_pkg::OP_CINIT: begin
          idx_nxt = '0;
        end
        ossc_pkg::OP_COUNT: begin
          pend_nxt = idx_in;
          if (idx_in) begin
            idx_nxt = idx_r + ENT_W'(1);
          end
        end
        ossc_pkg::OP_FIN: begin
          if (out_free) begin
            busy_nxt      = 1'b0;
            out_valid_nxt = 1'b1;
            out_count_nxt = err_r ? '0 : count_r;
            out_err_nxt   = err_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pc_r        <= ossc_pkg::ST_CHK;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      pc_r        <= pc_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    entries_r   <= entries_nxt;
    err_r       <= err_nxt;
    idx_r       <= idx_nxt;
    p_r         <= p_nxt;
    sq_r        <= sq_nxt;
    off_r       <= off_nxt;
    count_r     <= count_nxt;
    out_count_r <= out_count_nxt;
    out_err_r   <= out_err_nxt;
  end

  ossc_ram #(
    .WIDTH (1),
    .DEPTH (MARK_DEPTH)
  ) u_marks (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign out_valid           = out_valid_r;
  assign out_odd_prime_count = out_count_r;
  assign out_limit_error     = out_err_r;

  // The sequencer only runs past its first step while a transaction is open.
  a_idle_at_start: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> pc_r == ossc_pkg::ST_CHK)
    else $error("sequencer left its first step while idle");

  // Marks are only ever written inside the range of the current request.
  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (32'(mem_waddr) < 32'(entries_r)))
    else $error("mark store written beyond the current limit");

  // The running count can never exceed the number of marks of the request.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !err_r |-> (32'(count_r) <= 32'(entries_r)))
    else $error("prime count exceeds number of marks");

  // Finishing a request always leaves a result in the output register.
  a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> out_valid_r)
    else $error("request finished without a result");

  // A rejected limit reports a zero count.
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_err_r |-> out_count_r == '0)
    else $error("limit error with nonzero count");

endmodule
